>>> sv/pva_pkg.sv
package pva_pkg;

   // Fixed widths of the stream payloads
   localparam int MASK_W      = 36;
   localparam int KEY_BITS    = 6;
   localparam int KEY_SPACE   = 64;
   localparam int SLOT_COUNT  = 8;
   localparam int KEYS_W      = KEY_BITS * SLOT_COUNT;
   localparam int USED_W      = 4;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_DATA_W  = KEYS_W + SLOT_COUNT + USED_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RELEASE,
      ST_WALK,
      ST_EMIT
   } pva_state_type;

   typedef struct packed {
      logic load_mask;
      logic release_voices;
      logic walk_step;
      logic load_out;
   } pva_cmd_type;

   typedef struct packed {
      logic key_last;
   } pva_status_type;

endpackage

>>> sv/poly_voice_allocator.sv
// Polyphonic voice allocator, no voice stealing.
// Request channel (req_*): one keyboard scan per request, req_tdata[35:0] is the
//   pressed-key mask, bit k for key k; upper bits are ignored.
// Response channel (rsp_*): one response per request carrying each voice's key
//   (six bits per voice, zero when free), the active-voice mask and the count.
// Processing: released voices are freed all at once, then the keys are walked
//   one per cycle from key 0; a new pressed key takes the lowest free voice.
// Sequence: after a request is accepted the voices are released, the keys are walked
//   and the result is loaded into the output register, which raises rsp_tvalid.
// Requests: a new request is taken only after the previous one is loaded, so the pace
//   is set by the one-key-per-cycle walk through the key space unless the output stalls.
// Stall: a finished response sits in the output register; the next request is
//   taken and walked meanwhile, and its result waits until the register drains.
// Reset: synchronous, active high; all voices free, no response pending.
module poly_voice_allocator
   import pva_pkg::*;
#(
   parameter int NUM_KEYS   = 36,
   parameter int MAX_VOICES = 8
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [35:0] key_pressed_mask
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // [47:0] voice_keys, [55:48] voice_active,
                                              // [59:56] voices_used
);

   pva_cmd_type           cmd;
   pva_status_type        status;
   logic [RSP_DATA_W-1:0] rsp_data;

   // sequencer: accept, release, key walk, emit
   pva_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // voice table, key counter and output register
   pva_datapath #(
      .NUM_KEYS   (NUM_KEYS),
      .MAX_VOICES (MAX_VOICES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .mask     (req_tdata[MASK_W-1:0]),
      .rsp_data (rsp_data)
   );

   // pad the response to whole bytes
   assign rsp_tdata = {{(RSP_TDATA_W - RSP_DATA_W){1'b0}}, rsp_data};

endmodule

>>> sv/pva_ctrl.sv
module pva_ctrl
   import pva_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  pva_status_type status,
   output pva_cmd_type    cmd
);

   pva_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_mask = 1'b1;
               state_in      = ST_RELEASE;
            end
         end
         ST_RELEASE: begin
            cmd.release_voices = 1'b1;
            state_in           = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.key_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> sv/pva_datapath.sv
module pva_datapath
   import pva_pkg::*;
#(
   parameter int NUM_KEYS   = 36,
   parameter int MAX_VOICES = 8
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  pva_cmd_type            cmd,
   output pva_status_type         status,
   input  logic [MASK_W-1:0]      mask,
   output logic [RSP_DATA_W-1:0]  rsp_data
);

   localparam int KEY_CNT_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   logic [MASK_W-1:0]     mask_ff;
   logic [KEY_CNT_W-1:0]  key_cnt_ff, key_cnt_in;
   logic [MAX_VOICES-1:0] voice_valid_ff, voice_valid_in;
   logic [KEY_BITS-1:0]   voice_key_ff [MAX_VOICES];
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [KEY_SPACE-1:0]  mask_wide;
   logic [KEY_BITS-1:0]   cur_key;
   logic                  cur_pressed;
   logic                  cur_held;
   logic [MAX_VOICES-1:0] alloc_sel;
   logic                  lower_busy;
   logic                  do_alloc;

   assign mask_wide   = {{(KEY_SPACE - MASK_W){1'b0}}, mask_ff};
   assign cur_key     = KEY_BITS'(key_cnt_ff);
   assign cur_pressed = mask_wide[cur_key];

   assign status.key_last = (key_cnt_ff == KEY_CNT_W'(NUM_KEYS - 1));

   // hit search and lowest free voice, one key per step
   always_comb begin
      cur_held   = 1'b0;
      lower_busy = 1'b1;
      alloc_sel  = '0;
      for (int v = 0; v < MAX_VOICES; v++) begin
         if (voice_valid_ff[v] && (voice_key_ff[v] == cur_key)) begin
            cur_held = 1'b1;
         end
         alloc_sel[v] = lower_busy && !voice_valid_ff[v];
         lower_busy   = lower_busy && voice_valid_ff[v];
      end
   end

   assign do_alloc = cmd.walk_step && cur_pressed && !cur_held;

   always_comb begin
      voice_valid_in = voice_valid_ff;
      if (cmd.release_voices) begin
         for (int v = 0; v < MAX_VOICES; v++) begin
            voice_valid_in[v] = voice_valid_ff[v] && mask_wide[voice_key_ff[v]];
         end
      end else if (do_alloc) begin
         voice_valid_in = voice_valid_ff | alloc_sel;
      end
   end

   always_comb begin
      key_cnt_in = key_cnt_ff;
      if (cmd.load_mask) begin
         key_cnt_in = '0;
      end else if (cmd.walk_step && !status.key_last) begin
         key_cnt_in = key_cnt_ff + KEY_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_valid_ff <= '0;
         key_cnt_ff     <= '0;
      end else begin
         voice_valid_ff <= voice_valid_in;
         key_cnt_ff     <= key_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_mask) begin
         mask_ff <= mask;
      end
      for (int v = 0; v < MAX_VOICES; v++) begin
         if (do_alloc && alloc_sel[v]) begin
            voice_key_ff[v] <= cur_key;
         end
      end
      if (cmd.load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // assemble the result: keys, active mask, count
   always_comb begin
      logic [KEYS_W-1:0]     keys;
      logic [SLOT_COUNT-1:0] active;
      logic [USED_W-1:0]     used;
      keys   = '0;
      active = '0;
      used   = '0;
      for (int v = 0; v < MAX_VOICES; v++) begin
         if (voice_valid_ff[v]) begin
            keys[v*KEY_BITS +: KEY_BITS] = voice_key_ff[v];
            active[v]                    = 1'b1;
            used                         = used + USED_W'(1);
         end
      end
      rsp_data_in = {used, active, keys};
   end

   assign rsp_data = rsp_data_ff;

endmodule

>>> test/tb_poly_voice_allocator.sv
`timescale 1ns / 100ps

module tb_poly_voice_allocator
   import pva_pkg::*;
();

   localparam int NUM_KEYS     = 36;
   localparam int MAX_VOICES   = 8;
   // Length of one scan, used below to size the drain slack at the end of the run.
   localparam int SCAN_LATENCY = NUM_KEYS + 3;
   // Cycles with no request and no response accepted before giving up.
   localparam int STALL_LIMIT  = 4000;
   localparam int PRINT_LIMIT  = 40;

   typedef struct packed {
      logic [KEYS_W-1:0]     keys;
      logic [SLOT_COUNT-1:0] active;
      logic [USED_W-1:0]     used;
   } voice_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // [35:0] key_pressed_mask
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;       // [47:0] voice_keys, [55:48] voice_active,
                                            // [59:56] voices_used

   // Voice table as the allocator should hold it after each accepted scan.
   logic                voice_busy [SLOT_COUNT];
   logic [KEY_BITS-1:0] voice_note [SLOT_COUNT];

   voice_report_type expected_reports[$];
   int               error_count   = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               quiet_cycles  = 0;

   poly_voice_allocator #(
      .NUM_KEYS   (NUM_KEYS),
      .MAX_VOICES (MAX_VOICES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Keys past the mask width have no input bit and so are never pressed.
   function automatic logic key_down(input logic [MASK_W-1:0] mask, input int key);
      return (key < MASK_W) ? mask[key] : 1'b0;
   endfunction

   // Apply one scan to the voice table and build the response it must produce.
   function automatic voice_report_type allocate_voices(input logic [MASK_W-1:0] mask);
      voice_report_type report;
      int               used;
      logic             held;
      logic             placed;
      report = '0;
      used   = 0;
      // free every voice whose key was let go
      for (int v = 0; v < MAX_VOICES; v++) begin
         if (voice_busy[v] && !key_down(mask, int'(voice_note[v])))
            voice_busy[v] = 1'b0;
      end
      // walk keys upward; stop as soon as every voice counts as used
      for (int k = 0; k < NUM_KEYS && used < MAX_VOICES; k++) begin
         if (key_down(mask, k)) begin
            held = 1'b0;
            for (int v = 0; v < MAX_VOICES; v++) begin
               if (!held && voice_busy[v] && int'(voice_note[v]) == k) begin
                  held = 1'b1;
                  used++;
               end
            end
            placed = held;
            for (int v = 0; v < MAX_VOICES; v++) begin
               if (!placed && !voice_busy[v]) begin
                  voice_busy[v] = 1'b1;
                  voice_note[v] = KEY_BITS'(k);
                  placed        = 1'b1;
                  used++;
               end
            end
         end
      end
      // a voice is reported only while it holds a key; free slots read zero
      used = 0;
      for (int v = 0; v < MAX_VOICES; v++) begin
         if (voice_busy[v]) begin
            report.keys[KEY_BITS*v +: KEY_BITS] = voice_note[v];
            report.active[v] = 1'b1;
            used++;
         end
      end
      report.used = USED_W'(used);
      return report;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // Offer one scan, idling first at the sender's rate, and hold it until taken.
   // Valid is left high after a handshake so back-to-back requests never pulse low.
   task automatic send_scan(input logic [MASK_W-1:0] mask);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(mask);
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      expected_reports.push_back(allocate_voices(mask));
   endtask

   // Response side: check each accepted response, then pick next cycle's ready.
   always @(posedge clock) begin
      voice_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata, '0);
            end else begin
               want = expected_reports.pop_front();
               if (rsp_tdata[47:0] !== want.keys)
                  report_mismatch("voice_keys", 64'(rsp_tdata[47:0]), 64'(want.keys));
               if (rsp_tdata[55:48] !== want.active)
                  report_mismatch("voice_active", 64'(rsp_tdata[55:48]), 64'(want.active));
               if (rsp_tdata[59:56] !== want.used)
                  report_mismatch("voices_used", 64'(rsp_tdata[59:56]), 64'(want.used));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: drop the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("** poly_voice_allocator: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Empty scan, lowest and highest key alone, then every key at once.
   task automatic test_single_and_full;
      send_scan('0);
      send_scan(MASK_W'(1) << 0);
      send_scan(MASK_W'(1) << 35);                  // key 0 released, key 35 reuses voice 0
      send_scan('1);                                // voice 0 held, keys 0..6 fill the rest
      send_scan('0);
   endtask

   // Released voices free up and the lowest free voice goes to the next new key.
   task automatic test_release_and_reuse;
      logic [MASK_W-1:0] scan;
      scan = (MASK_W'(1) << 3) | (MASK_W'(1) << 10) | (MASK_W'(1) << 20);
      send_scan(scan);
      scan = (MASK_W'(1) << 3) | (MASK_W'(1) << 20) | (MASK_W'(1) << 30);
      send_scan(scan);                              // key 30 lands in the hole left by key 10
      scan |= MASK_W'(1) << 5;
      send_scan(scan);
      scan = (MASK_W'(1) << 1) | (MASK_W'(1) << 2) | (MASK_W'(1) << 5) | (MASK_W'(1) << 30);
      send_scan(scan);                              // two holes at once, filled in key order
      send_scan('0);
   endtask

   // More keys than voices: held voices stay, new keys wait for a free voice.
   task automatic test_voice_exhaustion;
      logic [MASK_W-1:0] scan;
      scan = 36'hF_F000_0000;                       // keys 28..35 take all eight voices
      send_scan(scan);
      scan |= 36'h0_0000_000F;                      // keys 0..3 find no voice
      send_scan(scan);
      scan &= ~((MASK_W'(1) << 30) | (MASK_W'(1) << 33));
      send_scan(scan);                              // keys 0 and 1 take the two freed voices
      send_scan('1);
      send_scan(MASK_W'(1) << 35);
      send_scan('0);
   endtask

   // Mostly a keyboard drifting press by press toward a target chord size,
   // with random masks, sparse masks and the all-off/all-on extremes mixed in.
   task automatic test_random_scans(input int count, input int send_pct, input int recv_pct);
      logic [MASK_W-1:0] scan;
      logic [63:0]       rand_word;
      int                target;
      int                run_left;
      int                pick;
      int                k;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      scan     = '0;
      target   = 4;
      run_left = 0;
      repeat (count) begin
         if (run_left == 0) begin
            target   = $urandom_range(1, 14);
            run_left = $urandom_range(8, 40);
         end
         run_left--;
         pick = $urandom_range(99);
         if (pick < 72) begin
            repeat ($urandom_range(1, 3)) begin
               k = $urandom_range(MASK_W - 1);
               if ($countones(scan) < target)
                  scan[k] = 1'b1;
               else if ($countones(scan) > target)
                  scan[k] = 1'b0;
               else
                  scan[k] = ~scan[k];
            end
         end else if (pick < 87) begin
            rand_word = {$urandom, $urandom};
            scan      = rand_word[MASK_W-1:0];
         end else if (pick < 95) begin
            scan = '0;
            repeat ($urandom_range(1, 4))
               scan[$urandom_range(MASK_W - 1)] = 1'b1;
         end else if (pick < 97) begin
            scan = '0;
         end else begin
            scan = '1;
         end
         send_scan(scan);
      end
   endtask

   initial begin
      for (int v = 0; v < SLOT_COUNT; v++) begin
         voice_busy[v] = 1'b0;
         voice_note[v] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 13;
      recv_idle_pct = 70;
      test_single_and_full;
      test_release_and_reuse;
      test_voice_exhaustion;
      test_random_scans(600, 13, 70);
      test_random_scans(600, 70, 13);
      test_random_scans(600, 0, 0);

      // drop valid, let every response drain, then allow a little slack
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0)
         @(posedge clock);
      repeat (2 * SCAN_LATENCY) @(posedge clock);

      if (error_count == 0)
         $display("** poly_voice_allocator: PASSED **");
      else
         $display("** poly_voice_allocator: FAILED **");
      $finish;
   end

endmodule
